@@ rtl/rfsa_pkg.sv @@
// Shared widths, register codes, reset values and types of the range filter aggregator.
`default_nettype none
package rfsa_pkg;

  localparam int ACT_W    = 10;
  localparam int REGION_W = 8;
  localparam int CALL_W   = 14;
  localparam int RANK_W   = 24;
  localparam int TID_W    = 8;
  localparam int BYTES_W  = 32;
  localparam int CNT_W    = 32;
  localparam int TIME_W   = 40;
  localparam int TTOT_W   = 48;

  localparam int MATCH_W  = 16;
  localparam int CSUM_W   = 48;
  localparam int TSUM_W   = 56;
  localparam int BSUM_W   = 63;
  localparam int PROD_W   = BYTES_W + CNT_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVITY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CALLSITE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANK       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THREAD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_LOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_HIGH = 3'd6;

  localparam logic [2*ACT_W-1:0]    RST_ACTIVITY   = 20'hFFC00;
  localparam logic [2*REGION_W-1:0] RST_REGION     = 16'hFF00;
  localparam logic [2*CALL_W-1:0]   RST_CALLSITE   = 28'hFFFC000;
  localparam logic [2*RANK_W-1:0]   RST_RANK       = 48'hFFFFFF000000;
  localparam logic [2*TID_W-1:0]    RST_THREAD     = 16'hFF00;
  localparam logic [BYTES_W-1:0]    RST_BYTES_LOW  = 32'h0;
  localparam logic [BYTES_W-1:0]    RST_BYTES_HIGH = 32'hFFFFFFFF;

  localparam int TIME_BITS_DEF   = 40;
  localparam int QUEUE_DEPTH_DEF = 4;

  // One table entry as it arrives.
  typedef struct packed {
    logic [ACT_W-1:0]    activity;
    logic [REGION_W-1:0] region;
    logic [CALL_W-1:0]   callsite;
    logic [RANK_W-1:0]   rank;
    logic [TID_W-1:0]    thread_id;
    logic [BYTES_W-1:0]  msg_bytes;
    logic [CNT_W-1:0]    entry_count;
    logic [TIME_W-1:0]   entry_tmin;
    logic [TIME_W-1:0]   entry_tmax;
    logic [TTOT_W-1:0]   entry_ttot;
    logic                last_entry;
  } entry_t;

  // A classified entry waiting in the queue for the accumulators.
  typedef struct packed {
    logic               hit;
    logic               last;
    logic [BYTES_W-1:0] msg_bytes;
    logic [CNT_W-1:0]   count;
    logic [TIME_W-1:0]  tmin;
    logic [TIME_W-1:0]  tmax;
    logic [TTOT_W-1:0]  ttot;
  } item_t;

  typedef struct packed {
    logic [MATCH_W-1:0] match_total;
    logic [CSUM_W-1:0]  count_total;
    logic [TSUM_W-1:0]  time_total;
    logic [TIME_W-1:0]  time_minimum;
    logic [TIME_W-1:0]  time_maximum;
    logic [BSUM_W-1:0]  byte_total;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/rfsa_in_if.sv @@
// Input channel interface: valid, ready and one table entry.
`default_nettype none
interface rfsa_in_if
  import rfsa_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    activity;
  logic [REGION_W-1:0] region;
  logic [CALL_W-1:0]   callsite;
  logic [RANK_W-1:0]   rank;
  logic [TID_W-1:0]    thread_id;
  logic [BYTES_W-1:0]  msg_bytes;
  logic [CNT_W-1:0]    entry_count;
  logic [TIME_W-1:0]   entry_tmin;
  logic [TIME_W-1:0]   entry_tmax;
  logic [TTOT_W-1:0]   entry_ttot;
  logic                last_entry;

  modport source (output valid, activity, region, callsite, rank, thread_id, msg_bytes,
                  entry_count, entry_tmin, entry_tmax, entry_ttot, last_entry,
                  input ready);
  modport sink (input valid, activity, region, callsite, rank, thread_id, msg_bytes,
                entry_count, entry_tmin, entry_tmax, entry_ttot, last_entry,
                output ready);
endinterface
`default_nettype wire

@@ rtl/rfsa_out_if.sv @@
// Result channel interface: valid, ready and one aggregate result.
`default_nettype none
interface rfsa_out_if
  import rfsa_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [MATCH_W-1:0] match_total;
  logic [CSUM_W-1:0]  count_total;
  logic [TSUM_W-1:0]  time_total;
  logic [TIME_W-1:0]  time_minimum;
  logic [TIME_W-1:0]  time_maximum;
  logic [BSUM_W-1:0]  byte_total;

  modport source (output valid, match_total, count_total, time_total, time_minimum,
                  time_maximum, byte_total, input ready);
  modport sink (input valid, match_total, count_total, time_total, time_minimum,
                time_maximum, byte_total, output ready);
endinterface
`default_nettype wire

@@ rtl/rfsa_cfg_if.sv @@
// Configuration write interface: valid, ready, register index and write data.
`default_nettype none
interface rfsa_cfg_if
  import rfsa_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

@@ rtl/rfsa_front.sv @@
// Front end: bound registers and classification of each entry against them.
`default_nettype none
module rfsa_front
  import rfsa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire entry_t                in_entry,
  output logic                       push_valid,
  input  wire logic                  push_ready,
  output item_t                      push_item
);

  logic [2*ACT_W-1:0]    act_bounds_r;
  logic [2*REGION_W-1:0] region_bounds_r;
  logic [2*CALL_W-1:0]   call_bounds_r;
  logic [2*RANK_W-1:0]   rank_bounds_r;
  logic [2*TID_W-1:0]    tid_bounds_r;
  logic [BYTES_W-1:0]    bytes_low_r;
  logic [BYTES_W-1:0]    bytes_high_r;
  logic                  hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_bounds_r    <= RST_ACTIVITY;
      region_bounds_r <= RST_REGION;
      call_bounds_r   <= RST_CALLSITE;
      rank_bounds_r   <= RST_RANK;
      tid_bounds_r    <= RST_THREAD;
      bytes_low_r     <= RST_BYTES_LOW;
      bytes_high_r    <= RST_BYTES_HIGH;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ACTIVITY:   act_bounds_r    <= cfg_wdata[2*ACT_W-1:0];
        REG_REGION:     region_bounds_r <= cfg_wdata[2*REGION_W-1:0];
        REG_CALLSITE:   call_bounds_r   <= cfg_wdata[2*CALL_W-1:0];
        REG_RANK:       rank_bounds_r   <= cfg_wdata[2*RANK_W-1:0];
        REG_THREAD:     tid_bounds_r    <= cfg_wdata[2*TID_W-1:0];
        REG_BYTES_LOW:  bytes_low_r     <= cfg_wdata[BYTES_W-1:0];
        REG_BYTES_HIGH: bytes_high_r    <= cfg_wdata[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // An entry with a nonzero count hits when each key field sits inside its
  // inclusive bounds; a low bound above the high bound rejects every entry.
  always_comb begin
    hit = (in_entry.entry_count != '0)
      && (in_entry.activity >= act_bounds_r[ACT_W-1:0])
      && (in_entry.activity <= act_bounds_r[2*ACT_W-1:ACT_W])
      && (in_entry.region >= region_bounds_r[REGION_W-1:0])
      && (in_entry.region <= region_bounds_r[2*REGION_W-1:REGION_W])
      && (in_entry.callsite >= call_bounds_r[CALL_W-1:0])
      && (in_entry.callsite <= call_bounds_r[2*CALL_W-1:CALL_W])
      && (in_entry.rank >= rank_bounds_r[RANK_W-1:0])
      && (in_entry.rank <= rank_bounds_r[2*RANK_W-1:RANK_W])
      && (in_entry.thread_id >= tid_bounds_r[TID_W-1:0])
      && (in_entry.thread_id <= tid_bounds_r[2*TID_W-1:TID_W])
      && (in_entry.msg_bytes >= bytes_low_r)
      && (in_entry.msg_bytes <= bytes_high_r);

    push_item.hit       = hit;
    push_item.last      = in_entry.last_entry;
    push_item.msg_bytes = in_entry.msg_bytes;
    push_item.count     = in_entry.entry_count;
    push_item.tmin      = in_entry.entry_tmin;
    push_item.tmax      = in_entry.entry_tmax;
    push_item.ttot      = in_entry.entry_ttot;
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule
`default_nettype wire

@@ rtl/rfsa_queue.sv @@
// Short first-in first-out queue of classified items between front and back.
`default_nettype none
module rfsa_queue
  import rfsa_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_item,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output item_t      pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t             slot_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]       fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign push_ready = (fill_r != (AW+1)'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

@@ rtl/rfsa_back.sv @@
// Back end: byte product stage, saturating accumulators and the result register.
`default_nettype none
module rfsa_back
  import rfsa_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  pop_valid,
  output logic       pop_ready,
  input  wire item_t pop_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    out_result
);

  // Only the low TW bits of a minimum or maximum time take part; a wider
  // setting adds nothing because the time fields themselves are TIME_W bits.
  localparam int TW = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;

  logic              a_valid_r;
  item_t             a_item_r;
  logic [PROD_W-1:0] a_prod_r;

  logic [MATCH_W-1:0] acc_matches_r, matches_nxt;
  logic [CSUM_W-1:0]  acc_count_r, count_nxt;
  logic [TSUM_W-1:0]  acc_time_r, time_nxt;
  logic [TW-1:0]      acc_min_r, min_nxt;
  logic [TW-1:0]      acc_max_r, max_nxt;
  logic [BSUM_W-1:0]  acc_bytes_r, bytes_nxt;

  logic               out_valid_r;
  result_t            out_result_r;

  logic               advance;
  logic               finish;
  logic [CSUM_W:0]    count_sum;
  logic [TSUM_W:0]    time_sum;
  logic [BSUM_W:0]    bytes_sum;
  logic [TW-1:0]      tmin_tw, tmax_tw;

  // A last item may only retire once the result register is free.
  assign advance   = !(a_valid_r && a_item_r.last && out_valid_r && !out_ready);
  assign pop_ready = advance;
  assign finish    = advance && a_valid_r && a_item_r.last;

  always_comb begin
    count_sum = {1'b0, acc_count_r} + (CSUM_W+1)'(a_item_r.count);
    time_sum  = {1'b0, acc_time_r} + (TSUM_W+1)'(a_item_r.ttot);
    bytes_sum = {1'b0, acc_bytes_r} + {1'b0, a_prod_r[BSUM_W-1:0]};
    tmin_tw   = a_item_r.tmin[TW-1:0];
    tmax_tw   = a_item_r.tmax[TW-1:0];

    matches_nxt = acc_matches_r;
    count_nxt   = acc_count_r;
    time_nxt    = acc_time_r;
    min_nxt     = acc_min_r;
    max_nxt     = acc_max_r;
    bytes_nxt   = acc_bytes_r;
    if (a_item_r.hit) begin
      matches_nxt = (acc_matches_r == '1) ? acc_matches_r : acc_matches_r + 1'b1;
      count_nxt   = count_sum[CSUM_W] ? '1 : count_sum[CSUM_W-1:0];
      time_nxt    = time_sum[TSUM_W] ? '1 : time_sum[TSUM_W-1:0];
      if (a_prod_r[PROD_W-1] || bytes_sum[BSUM_W]) begin
        bytes_nxt = '1;
      end else begin
        bytes_nxt = bytes_sum[BSUM_W-1:0];
      end
      if (tmin_tw < acc_min_r) begin
        min_nxt = tmin_tw;
      end
      if (tmax_tw > acc_max_r) begin
        max_nxt = tmax_tw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pop_valid) begin
      a_item_r <= pop_item;
      a_prod_r <= pop_item.msg_bytes * pop_item.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || finish) begin
      acc_matches_r <= '0;
      acc_count_r   <= '0;
      acc_time_r    <= '0;
      acc_min_r     <= '1;
      acc_max_r     <= '0;
      acc_bytes_r   <= '0;
    end else if (advance && a_valid_r) begin
      acc_matches_r <= matches_nxt;
      acc_count_r   <= count_nxt;
      acc_time_r    <= time_nxt;
      acc_min_r     <= min_nxt;
      acc_max_r     <= max_nxt;
      acc_bytes_r   <= bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_result_r.match_total  <= matches_nxt;
      out_result_r.count_total  <= count_nxt;
      out_result_r.time_total   <= time_nxt;
      out_result_r.time_minimum <= TIME_W'(min_nxt);
      out_result_r.time_maximum <= TIME_W'(max_nxt);
      out_result_r.byte_total   <= bytes_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule
`default_nettype wire

@@ rtl/range_filter_stats_aggregator_core.sv @@
// Top level of the range filter statistics aggregator.
//
// Channels: in_ch carries one event-table entry per item, out_ch carries one
// aggregate result per scan, cfg_ch writes the seven bound registers by index.
// An item or a write moves at a rising clock edge with valid and ready high.
// The configuration channel is always ready; indexes past the list are dropped.
// Throughput is one entry per cycle unless the back halts as below: the
// front classifies an entry in the cycle it is accepted and pushes it into a
// short queue, the back forms the 32 by 32 byte product in one stage and
// updates all accumulators in the next. Once the last entry of a scan is
// through its queue slot and the product stage, the result register holds
// the result until taken. If the receiver stalls, the back halts at the next
// last entry, the queue fills (QUEUE_DEPTH items) and then in_ch.ready drops;
// entries that are not last still flow into the accumulators while the
// current result waits. Reset (rst_n low, synchronous) restores the bound
// registers, clears the accumulators, the queue and any pending result.
module range_filter_stats_aggregator_core
  import rfsa_pkg::*;
#(
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  rfsa_in_if.sink    in_ch,
  rfsa_out_if.source out_ch,
  rfsa_cfg_if.sink   cfg_ch
);

  entry_t  in_entry;
  item_t   push_item;
  item_t   pop_item;
  result_t out_result;
  logic    in_ready;
  logic    push_valid, push_ready;
  logic    pop_valid, pop_ready;
  logic    out_valid;

  // Gather the entry fields into one word for the front end.
  always_comb begin
    in_entry.activity    = in_ch.activity;
    in_entry.region      = in_ch.region;
    in_entry.callsite    = in_ch.callsite;
    in_entry.rank        = in_ch.rank;
    in_entry.thread_id   = in_ch.thread_id;
    in_entry.msg_bytes   = in_ch.msg_bytes;
    in_entry.entry_count = in_ch.entry_count;
    in_entry.entry_tmin  = in_ch.entry_tmin;
    in_entry.entry_tmax  = in_ch.entry_tmax;
    in_entry.entry_ttot  = in_ch.entry_ttot;
    in_entry.last_entry  = in_ch.last_entry;
  end

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  rfsa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_wdata  (cfg_ch.wdata),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ready),
    .in_entry   (in_entry),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  rfsa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  rfsa_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .out_result (out_result)
  );

  // Spread the registered result over the output channel.
  assign out_ch.valid        = out_valid;
  assign out_ch.match_total  = out_result.match_total;
  assign out_ch.count_total  = out_result.count_total;
  assign out_ch.time_total   = out_result.time_total;
  assign out_ch.time_minimum = out_result.time_minimum;
  assign out_ch.time_maximum = out_result.time_maximum;
  assign out_ch.byte_total   = out_result.byte_total;

endmodule
`default_nettype wire
